// ===== design/kaau_pkg.sv =====
// ----------------------------------------------------------------------------
// kaau_pkg
// shared constants, codes and types of the k-means assign and update unit
// ----------------------------------------------------------------------------
package kaau_pkg;

  localparam int DEF_MAX_CENTERS = 16;
  localparam int DEF_MAX_DIMS    = 128;
  localparam int ELEMENT_BITS    = 8;
  localparam int FRACTION_BITS   = 8;
  localparam int VALUE_W         = 16;
  localparam int SUM_W           = 24;
  localparam int COUNT_W         = 17;
  localparam int DIST_W          = 39;
  localparam int PV_W            = ELEMENT_BITS + FRACTION_BITS;
  localparam int DIFF_W          = (PV_W > VALUE_W) ? PV_W : VALUE_W;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int QUO_W           = SUM_W + FRACTION_BITS;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_POINT  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic CFG_CENTERS = 1'b0;
  localparam logic CFG_DIMS    = 1'b1;

  // result kinds
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'b001,
    CMD_POINT  = 3'b010,
    CMD_UPDATE = 3'b100
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               in_range;
    logic [3:0]         center_index;
    logic [6:0]         element_index;
    logic [VALUE_W-1:0] value;
    logic               last_element;
    logic signed [4:0]  previous_label;
  } cmd_t;

endpackage

// ===== design/kaau_if.sv =====
// ----------------------------------------------------------------------------
// kaau_in_if / kaau_out_if
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
interface kaau_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [3:0]        center_index;
  logic [6:0]        element_index;
  logic [15:0]       value;
  logic              last_element;
  logic signed [4:0] previous_label;

  modport source (output valid, action, center_index, element_index, value,
                  last_element, previous_label, input ready);
  modport sink   (input valid, action, center_index, element_index, value,
                  last_element, previous_label, output ready);
endinterface

interface kaau_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [3:0]  label;
  logic [38:0] squared_distance;
  logic        changed;
  logic [16:0] change_count;

  modport source (output valid, result_kind, label, squared_distance, changed,
                  change_count, input ready);
  modport sink   (input valid, result_kind, label, squared_distance, changed,
                  change_count, output ready);
endinterface

// ===== design/kaau_front.sv =====
// ----------------------------------------------------------------------------
// kaau_front
// accepts input words, sorts them into commands and range-checks indexes
// ----------------------------------------------------------------------------
module kaau_front #(
  parameter int MAX_C = kaau_pkg::DEF_MAX_CENTERS,
  parameter int MAX_D = kaau_pkg::DEF_MAX_DIMS
) (
  kaau_in_if.sink        in,
  input  logic           full,
  output logic           push,
  output kaau_pkg::cmd_t cmd
);
  import kaau_pkg::*;

  logic eidx_ok;
  logic cidx_ok;

  assign in.ready = !full;
  assign eidx_ok  = int'(in.element_index) < MAX_D;
  assign cidx_ok  = int'(in.center_index) < MAX_C;

  always_comb begin
    cmd.center_index   = in.center_index;
    cmd.element_index  = in.element_index;
    cmd.value          = in.value;
    cmd.last_element   = in.last_element;
    cmd.previous_label = in.previous_label;
    cmd.kind           = CMD_LOAD;
    cmd.in_range       = 1'b0;
    push               = 1'b0;
    case (in.action)
      ACT_LOAD: begin
        cmd.kind     = CMD_LOAD;
        cmd.in_range = eidx_ok && cidx_ok;
        push         = in.valid && !full;
      end
      ACT_POINT: begin
        cmd.kind     = CMD_POINT;
        cmd.in_range = eidx_ok;
        push         = in.valid && !full;
      end
      ACT_UPDATE: begin
        cmd.kind = CMD_UPDATE;
        push     = in.valid && !full;
      end
      default: begin
        // unused action code: taken and dropped
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/kaau_queue.sv =====
// ----------------------------------------------------------------------------
// kaau_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module kaau_queue #(
  parameter int DEPTH = kaau_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kaau_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output kaau_pkg::cmd_t dout,
  output logic           empty
);
  import kaau_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full  = int'(fill) == DEPTH;
  assign empty = fill == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

// ===== design/kaau_div.sv =====
// ----------------------------------------------------------------------------
// kaau_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kaau_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kaau_pkg::QUO_W-1:0]   dividend,
  input  logic [kaau_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [kaau_pkg::QUO_W-1:0]   quotient
);
  import kaau_pkg::*;

  localparam int NW = $clog2(QUO_W + 1);

  logic               busy;
  logic [NW-1:0]      cnt;
  logic [COUNT_W:0]   rem;
  logic [COUNT_W-1:0] dvs;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_next;
  logic               q_bit;

  assign rem_sh   = {rem[COUNT_W-1:0], quotient[QUO_W-1]};
  assign q_bit    = rem_sh >= {1'b0, dvs};
  assign rem_next = q_bit ? rem_sh - {1'b0, dvs} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (int'(cnt) == QUO_W - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[QUO_W-2:0], q_bit};
    end
  end

endmodule

// ===== design/kaau_back.sv =====
// ----------------------------------------------------------------------------
// kaau_back
// command sequencer: center/point stores, distance search, accumulate, update
// ----------------------------------------------------------------------------
module kaau_back #(
  parameter int MAX_C = kaau_pkg::DEF_MAX_CENTERS,
  parameter int MAX_D = kaau_pkg::DEF_MAX_DIMS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  input  kaau_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  kaau_out_if.source     out
);
  import kaau_pkg::*;

  localparam int AW = $clog2(MAX_C * MAX_D);
  localparam int CW = (MAX_C > 1) ? $clog2(MAX_C) : 1;
  localparam int DW = (MAX_D > 1) ? $clog2(MAX_D) : 1;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SEARCH   = 8'b0000_0010,
    ST_REPORT   = 8'b0000_0100,
    ST_ACCUM    = 8'b0000_1000,
    ST_UPD_RD   = 8'b0001_0000,
    ST_UPD_GO   = 8'b0010_0000,
    ST_UPD_WAIT = 8'b0100_0000,
    ST_UPD_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [4:0]    centers_cfg;
  logic [7:0]    dims_cfg;
  logic [CW-1:0] k_last;
  logic [DW-1:0] d_last;

  // memories
  logic [VALUE_W-1:0]      center_mem [MAX_C*MAX_D];
  logic [ELEMENT_BITS-1:0] pb_mem     [MAX_D];
  logic [SUM_W-1:0]        sum_mem    [MAX_C*MAX_D];
  logic [VALUE_W-1:0]      center_rd;
  logic [ELEMENT_BITS-1:0] pb_rd;
  logic [SUM_W-1:0]        sum_rd;
  logic [AW-1:0]           center_raddr;
  logic [AW-1:0]           sum_raddr;
  logic                    center_we;
  logic [AW-1:0]           center_waddr;
  logic [VALUE_W-1:0]      center_wdata;
  logic                    pb_we;
  logic                    sum_we;
  logic [AW-1:0]           sum_waddr;
  logic [SUM_W-1:0]        sum_wdata;

  // sequencing
  logic [CW-1:0]       c_cnt;
  logic [DW-1:0]       j_cnt;
  logic                issuing;
  logic                s1_v;
  logic                s1_lastj;
  logic [CW-1:0]       s1_c;
  logic                s2_v;
  logic                s2_lastj;
  logic [CW-1:0]       s2_c;
  logic [PROD_W-1:0]   s2_prod;
  logic [DIST_W-1:0]   acc;
  logic [DIST_W-1:0]   dist_sum;
  logic [DIST_W-1:0]   best;
  logic [CW-1:0]       best_idx;
  logic signed [4:0]   prev_label;
  logic                chg;
  logic                acc_rv;
  logic [DW-1:0]       a_lim;
  logic                a1_v;
  logic [DW-1:0]       a1_j;
  logic                a1_in;
  logic                a1_last;
  logic [MAX_C-1:0]    row_valid;
  logic [COUNT_W-1:0]  counts [MAX_C];
  logic [COUNT_W-1:0]  changed_points;
  logic [PV_W-1:0]     pv;
  logic [DIFF_W-1:0]   diff;
  logic [SUM_W:0]      sum_add;
  logic [CW-1:0]       row_sel;

  // divider
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   dividend;
  logic [QUO_W-1:0]   quotient;
  logic [VALUE_W-1:0] mean;

  // output register
  logic               o_valid;
  logic               o_kind;
  logic [3:0]         o_label;
  logic [DIST_W-1:0]  o_dist;
  logic               o_changed;
  logic [COUNT_W-1:0] o_count;
  logic               out_free;

  assign out.valid            = o_valid;
  assign out.result_kind      = o_kind;
  assign out.label            = o_label;
  assign out.squared_distance = o_dist;
  assign out.changed          = o_changed;
  assign out.change_count     = o_count;
  assign out_free             = !o_valid || out.ready;

  always_comb begin
    int kc;
    int dc;
    kc = (centers_cfg == '0) ? 1 : ((int'(centers_cfg) > MAX_C) ? MAX_C : int'(centers_cfg));
    dc = (dims_cfg == '0) ? 1 : ((int'(dims_cfg) > MAX_D) ? MAX_D : int'(dims_cfg));
    k_last = CW'(kc - 1);
    d_last = DW'(dc - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_cfg <= 5'd16;
      dims_cfg    <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTERS: centers_cfg <= cfg_data[4:0];
        CFG_DIMS:    dims_cfg    <= cfg_data;
        default:     dims_cfg    <= dims_cfg;
      endcase
    end
  end

  // distance datapath
  assign pv   = PV_W'(pb_rd) << FRACTION_BITS;
  assign diff = (DIFF_W'(center_rd) >= DIFF_W'(pv)) ? DIFF_W'(center_rd) - DIFF_W'(pv)
                                                    : DIFF_W'(pv) - DIFF_W'(center_rd);
  assign dist_sum = acc + DIST_W'(s2_prod);
  assign chg  = int'(best_idx) != int'(prev_label);

  // accumulate datapath
  assign sum_add = {1'b0, (acc_rv ? sum_rd : '0)} + (SUM_W+1)'(pb_rd);

  // update datapath
  assign dividend = (row_valid[c_cnt] ? QUO_W'(sum_rd) : '0) << FRACTION_BITS;
  assign mean     = (counts[c_cnt] == '0) ? '0 :
                    ((quotient >> VALUE_W) != '0) ? {VALUE_W{1'b1}} : VALUE_W'(quotient);

  assign row_sel      = (state == ST_ACCUM) ? best_idx : c_cnt;
  assign center_raddr = AW'(int'(c_cnt) * MAX_D + int'(j_cnt));
  assign sum_raddr    = AW'(int'(row_sel) * MAX_D + int'(j_cnt));
  assign sum_waddr    = AW'(int'(best_idx) * MAX_D + int'(a1_j));
  assign sum_we       = (state == ST_ACCUM) && a1_v;
  assign sum_wdata    = !a1_in ? '0 : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);
  assign div_start    = state == ST_UPD_GO;

  always_comb begin
    pop          = 1'b0;
    pb_we        = 1'b0;
    center_we    = 1'b0;
    center_waddr = AW'(int'(head.center_index) * MAX_D + int'(head.element_index));
    center_wdata = head.value;
    case (state)
      ST_IDLE: begin
        pop = !empty;
        if (!empty && head.kind == CMD_LOAD)  center_we = head.in_range;
        if (!empty && head.kind == CMD_POINT) pb_we     = head.in_range;
      end
      ST_UPD_WAIT: begin
        center_we    = div_done;
        center_waddr = center_raddr;
        center_wdata = mean;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    center_rd <= center_mem[center_raddr];
    pb_rd     <= pb_mem[j_cnt];
    sum_rd    <= sum_mem[sum_raddr];
    if (center_we) center_mem[center_waddr] <= center_wdata;
    if (pb_we)     pb_mem[DW'(head.element_index)] <= head.value[ELEMENT_BITS-1:0];
    if (sum_we)    sum_mem[sum_waddr] <= sum_wdata;
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_lastj <= j_cnt == d_last;
    s1_c     <= c_cnt;
    s2_lastj <= s1_lastj;
    s2_c     <= s1_c;
    s2_prod  <= diff * diff;
    a1_j     <= j_cnt;
    a1_in    <= j_cnt <= d_last;
    a1_last  <= j_cnt == a_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      issuing        <= 1'b0;
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
      a1_v           <= 1'b0;
      row_valid      <= '0;
      changed_points <= '0;
      o_valid        <= 1'b0;
      c_cnt          <= '0;
      j_cnt          <= '0;
      for (int i = 0; i < MAX_C; i++) counts[i] <= '0;
    end else begin
      s1_v <= issuing && (state == ST_SEARCH);
      s2_v <= s1_v;
      a1_v <= issuing && (state == ST_ACCUM);
      // the reporting states load a new word themselves
      if (o_valid && out.ready && state != ST_REPORT && state != ST_UPD_FIN)
        o_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (!empty) begin
            c_cnt <= '0;
            j_cnt <= '0;
            if (head.kind == CMD_POINT && head.last_element) begin
              prev_label <= head.previous_label;
              acc        <= '0;
              issuing    <= 1'b1;
              state      <= ST_SEARCH;
            end else if (head.kind == CMD_UPDATE) begin
              state <= ST_UPD_RD;
            end
          end
        end

        ST_SEARCH: begin
          // one center element per cycle
          if (issuing) begin
            if (j_cnt == d_last) begin
              j_cnt <= '0;
              if (c_cnt == k_last) issuing <= 1'b0;
              else c_cnt <= c_cnt + 1'b1;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
          end
          if (s2_v) begin
            if (s2_lastj) begin
              acc <= '0;
              if (s2_c == '0 || dist_sum < best) begin
                best     <= dist_sum;
                best_idx <= s2_c;
              end
              if (s2_c == k_last) state <= ST_REPORT;
            end else begin
              acc <= dist_sum;
            end
          end
        end

        ST_REPORT: begin
          if (out_free) begin
            o_valid   <= 1'b1;
            o_kind    <= KIND_POINT;
            o_label   <= 4'(best_idx);
            o_dist    <= best;
            o_changed <= chg;
            o_count   <= '0;
            if (chg && changed_points != COUNT_MAX) changed_points <= changed_points + 1'b1;
            if (counts[best_idx] != COUNT_MAX) counts[best_idx] <= counts[best_idx] + 1'b1;
            // a fresh row is written out in full so stale sums never reappear
            acc_rv  <= row_valid[best_idx];
            a_lim   <= row_valid[best_idx] ? d_last : DW'(MAX_D - 1);
            j_cnt   <= '0;
            issuing <= 1'b1;
            state   <= ST_ACCUM;
          end
        end

        ST_ACCUM: begin
          if (issuing) begin
            if (j_cnt == a_lim) issuing <= 1'b0;
            else j_cnt <= j_cnt + 1'b1;
          end
          if (a1_v && a1_last) begin
            row_valid[best_idx] <= 1'b1;
            state               <= ST_IDLE;
          end
        end

        ST_UPD_RD: begin
          state <= ST_UPD_GO;
        end

        ST_UPD_GO: begin
          state <= ST_UPD_WAIT;
        end

        ST_UPD_WAIT: begin
          if (div_done) begin
            if (j_cnt == d_last) begin
              j_cnt <= '0;
              if (c_cnt == k_last) begin
                state <= ST_UPD_FIN;
              end else begin
                c_cnt <= c_cnt + 1'b1;
                state <= ST_UPD_RD;
              end
            end else begin
              j_cnt <= j_cnt + 1'b1;
              state <= ST_UPD_RD;
            end
          end
        end

        ST_UPD_FIN: begin
          if (out_free) begin
            o_valid        <= 1'b1;
            o_kind         <= KIND_UPDATE;
            o_label        <= '0;
            o_dist         <= '0;
            o_changed      <= 1'b0;
            o_count        <= changed_points;
            row_valid      <= '0;
            changed_points <= '0;
            for (int i = 0; i < MAX_C; i++) counts[i] <= '0;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  kaau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (counts[c_cnt]),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== design/kmeans_assign_and_update_unit.sv =====
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_unit
// one Lloyd k-means pass: nearest-center assignment, sums, means update
// ----------------------------------------------------------------------------
// Center loads and non-final point elements only write a memory. A point's final
// element runs a search over centers_in_use x dims_in_use center elements, one
// center element per cycle from the single read port of the center memory, then
// reports and adds the point into the sum memory over dims_in_use elements
// (MAX_DIMS for the first point of a center in a pass). An update computes
// centers_in_use x dims_in_use means with the bit-serial divider, which works
// one mean at a time. A 4-word queue lets input words be taken while the back
// end is busy or a result word waits. Sum memory needs no clearing pass after
// reset: per-center row valid bits stand in for it.
module kmeans_assign_and_update_unit #(
  parameter int MAX_CENTERS = kaau_pkg::DEF_MAX_CENTERS,
  parameter int MAX_DIMS    = kaau_pkg::DEF_MAX_DIMS
) (
  input  logic       clk,
  input  logic       rst,
  kaau_in_if.sink    in,
  kaau_out_if.source out,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import kaau_pkg::*;

  // front to queue
  cmd_t fe_cmd;
  logic fe_push;
  logic q_full;

  // queue to back
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  // classify and range-check input words
  kaau_front #(
    .MAX_C (MAX_CENTERS),
    .MAX_D (MAX_DIMS)
  ) u_front (
    .in   (in),
    .full (q_full),
    .push (fe_push),
    .cmd  (fe_cmd)
  );

  // decouples word acceptance from the long search and update passes
  kaau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .din   (fe_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // memories, search pipeline, accumulate and update sequencer
  kaau_back #(
    .MAX_C (MAX_CENTERS),
    .MAX_D (MAX_DIMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out       (out)
  );

endmodule

// ===== design/kaau_checker.sv =====
// ----------------------------------------------------------------------------
// kaau_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
module kaau_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [3:0]  out_label,
  input logic [38:0] out_dist,
  input logic        out_changed,
  input logic [16:0] out_count
);

  // stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_update_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> out_label == 4'd0 && out_dist == 39'd0 && !out_changed)
    else $error("update word carries point fields");

  a_point_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_kind |-> out_count == 17'd0)
    else $error("point word carries a change count");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind kmeans_assign_and_update_unit kaau_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out.valid),
  .out_ready   (out.ready),
  .out_kind    (out.result_kind),
  .out_label   (out.label),
  .out_dist    (out.squared_distance),
  .out_changed (out.changed),
  .out_count   (out.change_count)
);
